// File: sv/srmon_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the sensor running-average monitor.
package srmon_pkg;

    localparam int SENSORS_DEF = 16;
    localparam int WINDOW_DEF  = 8;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HOT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLD = 1'b1;

    localparam logic signed [15:0] HOT_RESET  = 16'sd7680;
    localparam logic signed [15:0] COLD_RESET = 16'sd2560;

    localparam logic [1:0] ACT_MAP   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [2:0] ST_FILLING = 3'd0;
    localparam logic [2:0] ST_NORMAL  = 3'd1;
    localparam logic [2:0] ST_HOT     = 3'd2;
    localparam logic [2:0] ST_COLD    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;
    localparam logic [2:0] ST_MAPPED  = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;
    localparam logic [2:0] ST_QUERY   = 3'd7;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_REMAP = 3'd1;
    localparam logic [2:0] OP_NEW   = 3'd2;
    localparam logic [2:0] OP_FILL  = 3'd3;
    localparam logic [2:0] OP_SLIDE = 3'd4;

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        sensor_tag;
        logic [15:0]        room_id;
        logic signed [15:0] sample;
    } srmon_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        reported_sensor;
        logic [15:0]        room_of_sensor;
        logic signed [15:0] running_average;
        logic               average_ready;
    } srmon_result_t;

    // Search token that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic               free_found;
        logic [15:0]        sensor_tag;
        logic [15:0]        room;
        logic signed [15:0] avg;
        logic               seen;
    } srmon_tok_t;

    // Update broadcast to every cell once the item is resolved.
    typedef struct packed {
        logic [2:0]         op;
        logic [15:0]        sensor_tag;
        logic [15:0]        room;
        logic signed [15:0] sample;
        logic signed [15:0] avg;
    } srmon_commit_t;

endpackage

// File: sv/srmon_cell.sv
`timescale 1ns / 1ps
// One table entry with its sample window, passing the search token to the next entry.
module srmon_cell #(
    parameter int WINDOW = srmon_pkg::WINDOW_DEF,
    localparam int FILL_W = $clog2(WINDOW + 1),
    localparam int SUM_W  = 16 + $clog2(WINDOW)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  srmon_pkg::srmon_tok_t      tok_in,
    input  logic [FILL_W-1:0]          fill_in,
    input  logic signed [SUM_W-1:0]    sum_in,
    input  logic signed [15:0]         oldest_in,
    output srmon_pkg::srmon_tok_t      tok_out,
    output logic [FILL_W-1:0]          fill_out,
    output logic signed [SUM_W-1:0]    sum_out,
    output logic signed [15:0]         oldest_out,
    input  srmon_pkg::srmon_commit_t   commit,
    input  logic signed [SUM_W-1:0]    commit_sum
);
    import srmon_pkg::*;

    logic                    used_reg, used_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic signed [15:0]      avg_reg, avg_next;
    logic                    seen_reg, seen_next;
    logic                    mark_hit_reg, mark_hit_next;
    logic                    mark_free_reg, mark_free_next;
    srmon_tok_t              tok_reg, tok_next;
    logic [15:0]             sensor_reg, sensor_next;
    logic [15:0]             room_reg, room_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [15:0]      win_reg [WINDOW];
    logic signed [15:0]      win_next [WINDOW];
    logic [FILL_W-1:0]       pfill_reg, pfill_next;
    logic signed [SUM_W-1:0] psum_reg, psum_next;
    logic signed [15:0]      pold_reg, pold_next;
    logic                    my_hit;
    logic                    my_free;
    logic                    selected;

    assign my_hit  = tok_in.valid && used_reg && (sensor_reg == tok_in.sensor_tag)
                     && !tok_in.found;
    assign my_free = tok_in.valid && !used_reg && !tok_in.free_found;

    always_comb
    begin
        tok_next       = tok_in;
        pfill_next     = fill_in;
        psum_next      = sum_in;
        pold_next      = oldest_in;
        mark_hit_next  = mark_hit_reg;
        mark_free_next = mark_free_reg;
        if (tok_in.valid)
        begin
            mark_hit_next  = my_hit;
            mark_free_next = my_free;
        end
        if (my_hit)
        begin
            tok_next.found = 1'b1;
            tok_next.room  = room_reg;
            tok_next.avg   = avg_reg;
            tok_next.seen  = seen_reg;
            pfill_next     = fill_reg;
            psum_next      = sum_reg;
            pold_next      = win_reg[0];
        end
        if (my_free)
        begin
            tok_next.free_found = 1'b1;
        end
    end

    assign selected = (commit.op == OP_NEW) ? mark_free_reg : mark_hit_reg;

    always_comb
    begin
        used_next   = used_reg;
        fill_next   = fill_reg;
        avg_next    = avg_reg;
        seen_next   = seen_reg;
        sensor_next = sensor_reg;
        room_next   = room_reg;
        sum_next    = sum_reg;
        for (int j = 0; j < WINDOW; j++)
        begin
            win_next[j] = win_reg[j];
        end
        if (selected)
        begin
            case (commit.op)
                OP_REMAP, OP_NEW:
                begin
                    used_next   = 1'b1;
                    sensor_next = commit.sensor_tag;
                    room_next   = commit.room;
                    fill_next   = '0;
                    avg_next    = '0;
                    seen_next   = 1'b0;
                    sum_next    = '0;
                end
                OP_FILL, OP_SLIDE:
                begin
                    sum_next = commit_sum;
                    for (int j = 0; j < WINDOW - 1; j++)
                    begin
                        win_next[j] = win_reg[j + 1];
                    end
                    win_next[WINDOW - 1] = commit.sample;
                    if (commit.op == OP_FILL)
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    else
                    begin
                        avg_next  = commit.avg;
                        seen_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= 1'b0;
            fill_reg      <= '0;
            avg_reg       <= '0;
            seen_reg      <= 1'b0;
            mark_hit_reg  <= 1'b0;
            mark_free_reg <= 1'b0;
            tok_reg       <= '0;
        end
        else
        begin
            used_reg      <= used_next;
            fill_reg      <= fill_next;
            avg_reg       <= avg_next;
            seen_reg      <= seen_next;
            mark_hit_reg  <= mark_hit_next;
            mark_free_reg <= mark_free_next;
            tok_reg       <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sensor_reg <= sensor_next;
        room_reg   <= room_next;
        sum_reg    <= sum_next;
        pfill_reg  <= pfill_next;
        psum_reg   <= psum_next;
        pold_reg   <= pold_next;
        for (int j = 0; j < WINDOW; j++)
        begin
            win_reg[j] <= win_next[j];
        end
    end

    assign tok_out    = tok_reg;
    assign fill_out   = pfill_reg;
    assign sum_out    = psum_reg;
    assign oldest_out = pold_reg;

endmodule

// File: sv/srmon_avg_div.sv
`timescale 1ns / 1ps
// Window average: signed sum divided by the window length through a reciprocal multiply.
module srmon_avg_div #(
    parameter int WINDOW = srmon_pkg::WINDOW_DEF,
    localparam int SUM_W = 16 + $clog2(WINDOW)
) (
    input  logic                    clk,
    input  logic                    load,
    input  logic signed [SUM_W-1:0] sum,
    output logic signed [15:0]      avg
);
    import srmon_pkg::*;

    localparam int LOG_W   = $clog2(WINDOW);
    localparam int SHIFT   = SUM_W + LOG_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int QUOT_W  = PROD_W - SHIFT;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [SUM_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [QUOT_W-1:0] quot;
    logic [QUOT_W-1:0] quot_signed;

    always_comb
    begin
        mag_next = mag_reg;
        neg_next = neg_reg;
        if (load)
        begin
            neg_next = sum[SUM_W-1];
            mag_next = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        end
        prod_next = PROD_W'(mag_reg) * PROD_W'(RECIP);
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
    end

    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign quot        = prod_reg[PROD_W-1:SHIFT];
    assign quot_signed = neg_reg ? -quot : quot;
    assign avg         = quot_signed[15:0];

endmodule

// File: sv/sensor_running_average_monitor_top.sv
`timescale 1ns / 1ps
// Top level of the sensor running-average monitor: sequencer, limits and the cell row.
//
//  Channel  | Signals                       | Handshake
//  ---------+-------------------------------+------------------------------------
//  item in  | start, busy, cmd              | taken when start is high, busy low
//  result   | done, result                  | one-cycle done strobe, no stall
//  config   | cfg_we, cfg_index, cfg_data   | written when cfg_we is high
//
// A map, reading or query item keeps busy high from its acceptance until it finishes:
// the search token walks the row one cell per cycle, then the average multiply
// registers the magnitude and then the product. The result strobe is registered from S_FINISH.
// An item with action code 3 is taken and dropped; busy stays low.
// Reset clears the entry flags and loads the limits; there is no clearing pass.
// The receiver cannot stall results, so none are ever held back.
module sensor_running_average_monitor_top #(
    parameter int SENSORS = srmon_pkg::SENSORS_DEF,
    parameter int WINDOW  = srmon_pkg::WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  srmon_pkg::srmon_item_t              cmd,
    output logic                                done,
    output srmon_pkg::srmon_result_t            result,
    input  logic                                cfg_we,
    input  logic [srmon_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data
);
    import srmon_pkg::*;

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = 16 + $clog2(WINDOW);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_CALC   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic signed [15:0]      hot_reg, hot_next;
    logic signed [15:0]      cold_reg, cold_next;
    logic                    done_reg, done_next;
    srmon_result_t           result_reg, result_next;
    logic [1:0]              act_reg, act_next;
    logic [15:0]             id_reg, id_next;
    logic [15:0]             room_reg, room_next;
    logic signed [15:0]      smp_reg, smp_next;
    logic                    found_reg, found_next;
    logic                    free_reg, free_next;
    logic [15:0]             e_room_reg, e_room_next;
    logic signed [15:0]      e_avg_reg, e_avg_next;
    logic                    e_seen_reg, e_seen_next;
    logic                    full_reg, full_next;
    logic signed [SUM_W-1:0] sum_new_reg, sum_new_next;
    logic signed [SUM_W-1:0] sum_new;
    logic                    accept;
    logic                    chain_end;
    logic signed [15:0]      div_avg;
    srmon_commit_t           commit;
    srmon_tok_t              tok_head;

    srmon_tok_t              tok_chain    [SENSORS + 1];
    logic [FILL_W-1:0]       fill_chain   [SENSORS + 1];
    logic signed [SUM_W-1:0] sum_chain    [SENSORS + 1];
    logic signed [15:0]      oldest_chain [SENSORS + 1];

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        tok_head            = '0;
        tok_head.valid      = accept && (cmd.action != ACT_NONE);
        tok_head.sensor_tag = cmd.sensor_tag;
    end

    assign tok_chain[0]    = tok_head;
    assign fill_chain[0]   = '0;
    assign sum_chain[0]    = '0;
    assign oldest_chain[0] = '0;

    for (genvar i = 0; i < SENSORS; i++)
    begin : g_cell
        srmon_cell #(
            .WINDOW (WINDOW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .tok_in     (tok_chain[i]),
            .fill_in    (fill_chain[i]),
            .sum_in     (sum_chain[i]),
            .oldest_in  (oldest_chain[i]),
            .tok_out    (tok_chain[i + 1]),
            .fill_out   (fill_chain[i + 1]),
            .sum_out    (sum_chain[i + 1]),
            .oldest_out (oldest_chain[i + 1]),
            .commit     (commit),
            .commit_sum (sum_new_reg)
        );
    end

    assign chain_end = tok_chain[SENSORS].valid;

    always_comb
    begin
        sum_new = sum_chain[SENSORS] + SUM_W'(smp_reg);
        if (fill_chain[SENSORS] == FILL_W'(WINDOW))
        begin
            sum_new = sum_new - SUM_W'(oldest_chain[SENSORS]);
        end
    end

    srmon_avg_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .clk  (clk),
        .load (chain_end),
        .sum  (sum_new),
        .avg  (div_avg)
    );

    always_comb
    begin
        hot_next  = hot_reg;
        cold_next = cold_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_HOT:  hot_next  = cfg_data;
                REG_COLD: cold_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        id_next      = id_reg;
        room_next    = room_reg;
        smp_next     = smp_reg;
        found_next   = found_reg;
        free_next    = free_reg;
        e_room_next  = e_room_reg;
        e_avg_next   = e_avg_reg;
        e_seen_next  = e_seen_reg;
        full_next    = full_reg;
        sum_new_next = sum_new_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next  = cmd.action;
                    id_next   = cmd.sensor_tag;
                    room_next = cmd.room_id;
                    smp_next  = cmd.sample;
                    if (cmd.action != ACT_NONE)
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (chain_end)
                begin
                    found_next   = tok_chain[SENSORS].found;
                    free_next    = tok_chain[SENSORS].free_found;
                    e_room_next  = tok_chain[SENSORS].room;
                    e_avg_next   = tok_chain[SENSORS].avg;
                    e_seen_next  = tok_chain[SENSORS].seen;
                    full_next    = (fill_chain[SENSORS] == FILL_W'(WINDOW));
                    sum_new_next = sum_new;
                    state_next   = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next                 = result_reg;
        done_next                   = 1'b0;
        commit.op                   = OP_NONE;
        commit.sensor_tag           = id_reg;
        commit.room                 = room_reg;
        commit.sample               = smp_reg;
        commit.avg                  = div_avg;
        if (state_reg == S_FINISH)
        begin
            done_next                   = 1'b1;
            result_next.status          = ST_UNKNOWN;
            result_next.reported_sensor = id_reg;
            result_next.room_of_sensor  = '0;
            result_next.running_average = '0;
            result_next.average_ready   = 1'b0;
            case (act_reg)
                ACT_MAP:
                begin
                    if (found_reg || free_reg)
                    begin
                        result_next.status         = ST_MAPPED;
                        result_next.room_of_sensor = room_reg;
                        commit.op = found_reg ? OP_REMAP : OP_NEW;
                    end
                    else
                    begin
                        result_next.status = ST_FULL;
                    end
                end
                ACT_READ:
                begin
                    if (found_reg && full_reg)
                    begin
                        if (div_avg > hot_reg)
                        begin
                            result_next.status = ST_HOT;
                        end
                        else if (div_avg < cold_reg)
                        begin
                            result_next.status = ST_COLD;
                        end
                        else
                        begin
                            result_next.status = ST_NORMAL;
                        end
                        result_next.room_of_sensor  = e_room_reg;
                        result_next.running_average = div_avg;
                        result_next.average_ready   = 1'b1;
                        commit.op                   = OP_SLIDE;
                    end
                    else if (found_reg)
                    begin
                        result_next.status          = ST_FILLING;
                        result_next.room_of_sensor  = e_room_reg;
                        result_next.running_average = e_avg_reg;
                        result_next.average_ready   = e_seen_reg;
                        commit.op                   = OP_FILL;
                    end
                end
                ACT_QUERY:
                begin
                    if (found_reg)
                    begin
                        result_next.status          = ST_QUERY;
                        result_next.room_of_sensor  = e_room_reg;
                        result_next.running_average = e_avg_reg;
                        result_next.average_ready   = e_seen_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hot_reg   <= HOT_RESET;
            cold_reg  <= COLD_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hot_reg   <= hot_next;
            cold_reg  <= cold_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        act_reg     <= act_next;
        id_reg      <= id_next;
        room_reg    <= room_next;
        smp_reg     <= smp_next;
        found_reg   <= found_next;
        free_reg    <= free_next;
        e_room_reg  <= e_room_next;
        e_avg_reg   <= e_avg_next;
        e_seen_reg  <= e_seen_next;
        full_reg    <= full_next;
        sum_new_reg <= sum_new_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FINISH))
        else $error("result strobe without a finished item");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.action != ACT_NONE)) |=> busy)
        else $error("accepted item did not start a search");

    a_token_only_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain_end |-> (state_reg == S_SEARCH))
        else $error("search token left the cell row outside a search");

    a_commit_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (commit.op != OP_NONE) |-> (state_reg == S_FINISH) && done_next)
        else $error("cell update outside the finishing cycle");

endmodule
